// ===== hw/rtl/sysex_seven_bit_packer_core_assert.svh =====
// Assertion helpers shared by the packer's queue and sequencer modules.
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef SYSEX_SEVEN_BIT_PACKER_CORE_ASSERT_SVH
`define SYSEX_SEVEN_BIT_PACKER_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SXP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SXP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sxp_pkg.sv =====
package sxp_pkg;

	localparam logic [7:0] SOX_BYTE  = 8'hF0;
	localparam logic [7:0] EOX_BYTE  = 8'hF7;
	localparam logic [7:0] LOW7_MASK = 8'h7F;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MAKER_ID_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAKER_ID_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAKER_ID_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CODE    = 3'd3;

	// Header bytes as held by the configuration registers.
	typedef struct packed {
		logic [6:0] maker_id_first;
		logic [6:0] maker_id_second;
		logic [6:0] maker_id_third;
		logic [6:0] command_code;
	} hdr_cfg_t;

	// One classified item, handed from the front to the sequencer.
	typedef struct packed {
		logic       hdr;       // send 0xF0, ids and command first
		logic [6:0] data7;     // payload byte with its top bit cleared
		logic [1:0] npad;      // zero pad bytes after the data byte
		logic       emit_top;  // close the group with its top-bit byte
		logic [3:0] top;       // gathered top bits of the closing group
		logic       eox;       // finish with 0xF7
	} job_t;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_SOX  = 10'b00_0000_0010,
		ST_ID1  = 10'b00_0000_0100,
		ST_ID2  = 10'b00_0000_1000,
		ST_ID3  = 10'b00_0001_0000,
		ST_CMD  = 10'b00_0010_0000,
		ST_DATA = 10'b00_0100_0000,
		ST_PAD  = 10'b00_1000_0000,
		ST_TOP  = 10'b01_0000_0000,
		ST_EOX  = 10'b10_0000_0000
	} seq_state_t;

endpackage

// ===== hw/rtl/sxp_front.sv =====
module sxp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        payload_byte,
	input  logic              starts_message,
	input  logic              ends_message,
	input  logic              q_full,
	output logic              q_push,
	output sxp_pkg::job_t     q_job
);

	logic [1:0] group_pos_q;
	logic [3:0] top_bits_q;
	logic [1:0] pos;
	logic [3:0] gath;
	logic [3:0] top_new;
	logic       full;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	// A start mark drops any partial group.
	assign pos     = starts_message ? 2'd0 : group_pos_q;
	assign gath    = starts_message ? 4'd0 : top_bits_q;
	assign top_new = gath | ({3'b000, payload_byte[7]} << pos);
	assign full    = (pos == 2'd3);

	always_comb begin
		q_job          = '0;
		q_job.hdr      = starts_message;
		q_job.data7    = payload_byte[6:0];
		q_job.npad     = (ends_message && !full) ? (2'd3 - pos) : 2'd0;
		q_job.emit_top = full || ends_message;
		q_job.top      = top_new;
		q_job.eox      = ends_message;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_pos_q <= 2'd0;
			top_bits_q  <= 4'd0;
		end else if (accept) begin
			if (full || ends_message) begin
				group_pos_q <= 2'd0;
				top_bits_q  <= 4'd0;
			end else begin
				group_pos_q <= pos + 2'd1;
				top_bits_q  <= top_new;
			end
		end
	end

endmodule

// ===== hw/rtl/sxp_queue.sv =====
`include "sysex_seven_bit_packer_core_assert.svh"

module sxp_queue #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SXP_ASSERT_IMP(a_no_push_full, full, !push, "push into a full queue")
	`SXP_ASSERT_IMP(a_no_pop_empty, empty, !pop, "pop from an empty queue")
	`SXP_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ===== hw/rtl/sxp_back.sv =====
`include "sysex_seven_bit_packer_core_assert.svh"

module sxp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sxp_pkg::hdr_cfg_t hdr_cfg,
	input  logic              q_empty,
	input  sxp_pkg::job_t     q_job,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        stream_byte,
	output logic              final_of_run
);

	sxp_pkg::seq_state_t state_q;
	sxp_pkg::seq_state_t state_next;

	logic [6:0] data7_q;
	logic [1:0] pad_cnt_q;
	logic       emit_top_q;
	logic [3:0] top_q;
	logic       eox_q;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       final_q;

	logic       adv;
	logic [7:0] byte_next;
	logic       final_next;

	assign out_valid    = out_valid_q;
	assign stream_byte  = byte_q;
	assign final_of_run = final_q;

	assign adv   = (state_q != sxp_pkg::ST_IDLE) && (!out_valid_q || !out_stall);
	assign q_pop = (state_q == sxp_pkg::ST_IDLE) && !q_empty;

	always_comb begin
		byte_next  = 8'h00;
		final_next = 1'b0;
		state_next = state_q;
		unique case (state_q)
			sxp_pkg::ST_IDLE: begin
				state_next = q_job.hdr ? sxp_pkg::ST_SOX : sxp_pkg::ST_DATA;
			end
			sxp_pkg::ST_SOX: begin
				byte_next  = sxp_pkg::SOX_BYTE;
				state_next = sxp_pkg::ST_ID1;
			end
			sxp_pkg::ST_ID1: begin
				byte_next  = {1'b0, hdr_cfg.maker_id_first};
				state_next = sxp_pkg::ST_ID2;
			end
			sxp_pkg::ST_ID2: begin
				byte_next  = {1'b0, hdr_cfg.maker_id_second};
				state_next = sxp_pkg::ST_ID3;
			end
			sxp_pkg::ST_ID3: begin
				byte_next  = {1'b0, hdr_cfg.maker_id_third};
				state_next = sxp_pkg::ST_CMD;
			end
			sxp_pkg::ST_CMD: begin
				byte_next  = {1'b0, hdr_cfg.command_code};
				state_next = sxp_pkg::ST_DATA;
			end
			sxp_pkg::ST_DATA: begin
				byte_next = {1'b0, data7_q};
				if (pad_cnt_q != 2'd0) begin
					state_next = sxp_pkg::ST_PAD;
				end else if (emit_top_q) begin
					state_next = sxp_pkg::ST_TOP;
				end else if (eox_q) begin
					state_next = sxp_pkg::ST_EOX;
				end else begin
					state_next = sxp_pkg::ST_IDLE;
					final_next = 1'b1;
				end
			end
			sxp_pkg::ST_PAD: begin
				byte_next = 8'h00;
				if (pad_cnt_q == 2'd1) begin
					state_next = sxp_pkg::ST_TOP;
				end
			end
			sxp_pkg::ST_TOP: begin
				byte_next = {4'h0, top_q};
				if (eox_q) begin
					state_next = sxp_pkg::ST_EOX;
				end else begin
					state_next = sxp_pkg::ST_IDLE;
					final_next = 1'b1;
				end
			end
			sxp_pkg::ST_EOX: begin
				byte_next  = sxp_pkg::EOX_BYTE;
				state_next = sxp_pkg::ST_IDLE;
				final_next = 1'b1;
			end
			default: begin
				state_next = sxp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sxp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			pad_cnt_q   <= 2'd0;
		end else begin
			if (q_pop) begin
				state_q   <= state_next;
				pad_cnt_q <= q_job.npad;
			end else if (adv) begin
				state_q <= state_next;
				if (state_q == sxp_pkg::ST_PAD) begin
					pad_cnt_q <= pad_cnt_q - 2'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data7_q    <= q_job.data7;
			emit_top_q <= q_job.emit_top;
			top_q      <= q_job.top;
			eox_q      <= q_job.eox;
		end
		if (adv) begin
			byte_q  <= byte_next;
			final_q <= final_next;
		end
	end

	`SXP_ASSERT_IMP(a_pad_closes, state_q == sxp_pkg::ST_PAD,
		pad_cnt_q != 2'd0 && emit_top_q, "pad step without a pending count or top byte")
	`SXP_ASSERT_NEXT(a_final_idle, adv && final_next,
		state_q == sxp_pkg::ST_IDLE, "last beat of an item left the sequencer busy")
	`SXP_ASSERT_NEXT(a_hold_on_stall, state_q != sxp_pkg::ST_IDLE && !adv,
		$stable(state_q), "sequencer moved while the output was stalled")

endmodule

// ===== hw/rtl/sysex_seven_bit_packer_core.sv =====
// Channel    Direction  Handshake            Beat contents
// in         sink       in_valid/in_stall    payload_byte, starts_message, ends_message
// out        source     out_valid/out_stall  stream_byte, final_of_run
// cfg        sink       cfg_we               cfg_index, cfg_data (7-bit header registers)
//
// The front takes one input beat per cycle while the job queue has room.
// The sequencer takes a job from the queue while idle, then walks out its output beats
// (1 to 11 per job) and returns to idle before it takes the next job.
// In a job, beats leave one per cycle unless out stalls, via a single output register.
// arst_n resets group state, queue, sequencer (to idle) and header registers (to zero).
// A stall on out holds the sequencer; the queue lets in keep going until it fills.
module sysex_seven_bit_packer_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     payload_byte,
	input  logic                           starts_message,
	input  logic                           ends_message,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     stream_byte,
	output logic                           final_of_run,
	input  logic                           cfg_we,
	input  logic [sxp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sxp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int JOB_W = $bits(sxp_pkg::job_t);

	sxp_pkg::hdr_cfg_t hdr_cfg_q;
	sxp_pkg::job_t     push_job;
	sxp_pkg::job_t     pop_job;
	logic [JOB_W-1:0]  pop_bits;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;

	// Header registers; writes to unused indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sxp_pkg::REG_MAKER_ID_FIRST:  hdr_cfg_q.maker_id_first  <= cfg_data;
				sxp_pkg::REG_MAKER_ID_SECOND: hdr_cfg_q.maker_id_second <= cfg_data;
				sxp_pkg::REG_MAKER_ID_THIRD:  hdr_cfg_q.maker_id_third  <= cfg_data;
				sxp_pkg::REG_COMMAND_CODE:    hdr_cfg_q.command_code    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Classify each beat and track the open seven-bit group.
	sxp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.payload_byte   (payload_byte),
		.starts_message (starts_message),
		.ends_message   (ends_message),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_job          (push_job)
	);

	// Short job queue between classification and byte sequencing.
	sxp_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_job),
		.pop       (q_pop),
		.pop_data  (pop_bits),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign pop_job = sxp_pkg::job_t'(pop_bits);

	// Walk each job out as header, data, pads, top-bit byte and end mark.
	sxp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.hdr_cfg      (hdr_cfg_q),
		.q_empty      (q_empty),
		.q_job        (pop_job),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.stream_byte  (stream_byte),
		.final_of_run (final_of_run)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT   = 250000;
	localparam int RANDOM_ITEMS  = 80;
	localparam int SETTLE_CYCLES = 16;

	// One beat of the outgoing sysex stream as the block should present it.
	typedef struct {
		logic [7:0] stream_byte;
		logic       final_of_run;
	} stream_beat_t;

	// Packs accepted payload beats into the sysex bytes they must produce and
	// checks the block's output beats against them in order.
	class sysex_stream_scoreboard;
		logic [6:0]   maker_id_first;
		logic [6:0]   maker_id_second;
		logic [6:0]   maker_id_third;
		logic [6:0]   command_code;
		int           group_fill;
		logic [3:0]   group_top_bits;
		stream_beat_t pending_stream[$];
		int           mismatches;

		function new();
			maker_id_first = '0;
			maker_id_second = '0;
			maker_id_third = '0;
			command_code = '0;
			group_fill = 0;
			group_top_bits = '0;
			mismatches = 0;
		endfunction

		function void set_register(logic [sxp_pkg::CFG_IDX_W-1:0] idx,
				logic [sxp_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				sxp_pkg::REG_MAKER_ID_FIRST: maker_id_first = data;
				sxp_pkg::REG_MAKER_ID_SECOND: maker_id_second = data;
				sxp_pkg::REG_MAKER_ID_THIRD: maker_id_third = data;
				sxp_pkg::REG_COMMAND_CODE: command_code = data;
				default: ;
			endcase
		endfunction

		function void push_byte(logic [7:0] b);
			stream_beat_t beat;
			beat.stream_byte = b;
			beat.final_of_run = 1'b0;
			pending_stream.push_back(beat);
		endfunction

		// Send the low seven bits; close the group with its top-bit byte once it holds four.
		function void pack_data(logic [7:0] b);
			push_byte(b & sxp_pkg::LOW7_MASK);
			group_top_bits[group_fill] = b[7];
			group_fill++;
			if (group_fill == 4) begin
				push_byte({4'b0, group_top_bits});
				group_fill = 0;
				group_top_bits = '0;
			end
		endfunction

		function void note_payload_beat(logic [7:0] b, logic starts, logic ends);
			if (starts) begin
				// A start always drops any partial group and resends the header.
				group_fill = 0;
				group_top_bits = '0;
				push_byte(sxp_pkg::SOX_BYTE);
				push_byte({1'b0, maker_id_first});
				push_byte({1'b0, maker_id_second});
				push_byte({1'b0, maker_id_third});
				push_byte({1'b0, command_code});
			end
			pack_data(b);
			if (ends) begin
				// Pad with zero bytes until the group closes, then end of exclusive.
				while (group_fill != 0)
					pack_data(8'h00);
				push_byte(sxp_pkg::EOX_BYTE);
			end
			pending_stream[pending_stream.size() - 1].final_of_run = 1'b1;
		endfunction

		function void check_stream_beat(logic [7:0] b, logic fin);
			stream_beat_t exp_beat;
			if (pending_stream.size() == 0) begin
				$error("stream_byte: no beat expected, got %02h (final_of_run %0b)", b, fin);
				mismatches++;
				return;
			end
			exp_beat = pending_stream.pop_front();
			if (b !== exp_beat.stream_byte) begin
				$error("stream_byte: expected %02h, got %02h", exp_beat.stream_byte, b);
				mismatches++;
			end
			if (fin !== exp_beat.final_of_run) begin
				$error("final_of_run: expected %0b, got %0b", exp_beat.final_of_run, fin);
				mismatches++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     payload_byte;
	logic                           starts_message;
	logic                           ends_message;
	logic                           out_valid;
	logic                           out_stall;
	logic [7:0]                     stream_byte;
	logic                           final_of_run;
	logic                           cfg_we;
	logic [sxp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sxp_pkg::CFG_DATA_W-1:0] cfg_data;

	int                     sender_idle_pct;
	int                     receiver_stall_pct;
	int                     cycle_count;
	sysex_stream_scoreboard sb;

	sysex_seven_bit_packer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.payload_byte  (payload_byte),
		.starts_message(starts_message),
		.ends_message  (ends_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stream_byte   (stream_byte),
		.final_of_run  (final_of_run),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: check every accepted beat, then pick next cycle's stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_stream_beat(stream_byte, final_of_run);
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one payload beat, idling first at the current rate, and hold it
	// until the block takes it.
	task automatic send_payload_beat(logic [7:0] b, logic starts, logic ends);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		payload_byte <= b;
		starts_message <= starts;
		ends_message <= ends;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_payload_beat(b, starts, ends);
	endtask

	// Well-formed message: start mark on the first byte, end mark on the last.
	task automatic send_message(int len);
		for (int i = 0; i < len; i++)
			send_payload_beat(8'($urandom_range(0, 255)), i == 0, i == len - 1);
	endtask

	// Wait until every expected beat has arrived, then let the block settle.
	task automatic drain_stream();
		in_valid <= 1'b0;
		while (sb.pending_stream.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four header registers, then every unused index with random
	// data; the block must ignore those. Call only with the block idle.
	task automatic write_header_regs(logic [6:0] id1, logic [6:0] id2, logic [6:0] id3,
			logic [6:0] cmd);
		logic [sxp_pkg::CFG_DATA_W-1:0] vals [2**sxp_pkg::CFG_IDX_W];
		for (int i = 0; i < 2**sxp_pkg::CFG_IDX_W; i++)
			vals[i] = sxp_pkg::CFG_DATA_W'($urandom);
		vals[sxp_pkg::REG_MAKER_ID_FIRST] = id1;
		vals[sxp_pkg::REG_MAKER_ID_SECOND] = id2;
		vals[sxp_pkg::REG_MAKER_ID_THIRD] = id3;
		vals[sxp_pkg::REG_COMMAND_CODE] = cmd;
		cfg_we <= 1'b1;
		for (int i = 0; i < 2**sxp_pkg::CFG_IDX_W; i++) begin
			cfg_index <= sxp_pkg::CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_register(sxp_pkg::CFG_IDX_W'(i), vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly whole messages of random content and length, with some stray
	// beats carrying random marks to break them up.
	task automatic run_random_phase(int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(10, 20);
				else
					len = $urandom_range(1, 9);
				send_message(len);
				sent += len;
			end else begin
				send_payload_beat(8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom));
				sent++;
			end
		end
		drain_stream();
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		payload_byte <= '0;
		starts_message <= 1'b0;
		ends_message <= 1'b0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. First a one-byte message on the reset header.
		send_payload_beat(8'hFF, 1'b1, 1'b1);
		drain_stream();
		write_header_regs(7'h7F, 7'h00, 7'h55, 7'h2A);

		// End on a full group: no padding.
		send_payload_beat(8'h80, 1'b1, 1'b0);
		send_payload_beat(8'h7F, 1'b0, 1'b0);
		send_payload_beat(8'h00, 1'b0, 1'b0);
		send_payload_beat(8'hFF, 1'b0, 1'b1);
		// Partial groups padded by two and by one zero byte.
		send_payload_beat(8'h81, 1'b1, 1'b0);
		send_payload_beat(8'h01, 1'b0, 1'b1);
		send_payload_beat(8'hAA, 1'b1, 1'b0);
		send_payload_beat(8'h55, 1'b0, 1'b0);
		send_payload_beat(8'hC3, 1'b0, 1'b1);
		// Bytes with no start mark outside a message: packed, no header.
		send_payload_beat(8'h80, 1'b0, 1'b0);
		send_payload_beat(8'hFE, 1'b0, 1'b0);
		send_payload_beat(8'h01, 1'b0, 1'b1);
		// Restart inside a message drops the partial group.
		send_payload_beat(8'hF0, 1'b1, 1'b0);
		send_payload_beat(8'h8F, 1'b0, 1'b0);
		send_payload_beat(8'h77, 1'b1, 1'b1);
		// Start and end on a zero byte.
		send_payload_beat(8'h00, 1'b1, 1'b1);
		// Five bytes: a full group, then a padded one.
		send_payload_beat(8'h90, 1'b1, 1'b0);
		send_payload_beat(8'h11, 1'b0, 1'b0);
		send_payload_beat(8'hE2, 1'b0, 1'b0);
		send_payload_beat(8'h33, 1'b0, 1'b0);
		send_payload_beat(8'hC4, 1'b0, 1'b1);
		// Stray byte, left open into the next phase.
		send_payload_beat(8'hFF, 1'b0, 1'b0);
		drain_stream();

		// Random phases: header extremes first, then random headers, each with
		// its own idling profile.
		write_header_regs(7'h00, 7'h00, 7'h00, 7'h00);
		run_random_phase(RANDOM_ITEMS);

		write_header_regs(7'h7F, 7'h7F, 7'h7F, 7'h7F);
		sender_idle_pct = 54;
		run_random_phase(RANDOM_ITEMS);

		write_header_regs(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
		sender_idle_pct = 0;
		receiver_stall_pct = 54;
		run_random_phase(RANDOM_ITEMS);

		write_header_regs(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
		sender_idle_pct = 27;
		receiver_stall_pct = 27;
		run_random_phase(RANDOM_ITEMS);

		if (sb.mismatches == 0 && sb.pending_stream.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
